// File: sv/msup_pkg.sv
// Shared types and constants for the motor unit message supervisor.
// Used by msup_ctrl, msup_dpath and the top level; depends on nothing.
package msup_pkg;

    localparam int unsigned NUM_SRC = 3;
    localparam int unsigned SRC_BATTERY = 0;
    localparam int unsigned SRC_GEARBOX = 1;
    localparam int unsigned SRC_VEHICLE = 2;
    localparam int unsigned DIV_STEPS = 16;

    localparam logic [1:0] CFG_MAX_POWER = 2'd0;
    localparam logic [1:0] CFG_UV_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TO_LIMIT = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_UNDERVOLT = 2'd2;

    localparam logic [19:0] MAX_POWER_RST = 20'd100000;
    localparam logic [15:0] UV_LIMIT_RST = 16'd300;
    localparam logic [7:0] TO_LIMIT_RST = 8'd5;
    localparam logic [6:0] PERCENT_SCALE = 7'd100;
    localparam logic [15:0] CURRENT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_RESULT
    } state_t;

    // Packed with the first field in the highest bits.
    typedef struct packed {
        logic [15:0] motor_speed;
        logic [15:0] motor_torque;
        logic [7:0]  vehicle_byte2;
        logic [7:0]  vehicle_byte1;
        logic [7:0]  vehicle_byte0;
        logic        vehicle_msg_valid;
        logic        gearbox_msg_valid;
        logic [7:0]  battery_byte1;
        logic [7:0]  battery_byte0;
        logic        battery_msg_valid;
    } in_item_t;

    typedef struct packed {
        logic [15:0] speed_word;
        logic [15:0] torque_word;
        logic [15:0] motor_current;
        logic [15:0] motor_voltage;
        logic [1:0]  error_code;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic load_mul;
        logic init_div;
        logic step_div;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

// File: sv/msup_ctrl.sv
// Sequencing state machine of the motor unit message supervisor.
// Uses msup_pkg; drives command signals to msup_dpath and owns the s_ and m_ handshakes.
module msup_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  msup_pkg::status_t status,
    output msup_pkg::cmd_t    cmd
);

    msup_pkg::state_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msup_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msup_pkg::ST_IDLE:   if (s_tvalid) state_next = msup_pkg::ST_MUL;
            msup_pkg::ST_MUL:    state_next = msup_pkg::ST_INIT;
            msup_pkg::ST_INIT:   state_next = msup_pkg::ST_DIV;
            msup_pkg::ST_DIV:    if (status.div_last) state_next = msup_pkg::ST_RESULT;
            msup_pkg::ST_RESULT: if (out_free) state_next = msup_pkg::ST_IDLE;
            default:             state_next = msup_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            msup_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.accept = s_tvalid;
            end
            msup_pkg::ST_MUL:    cmd.load_mul = 1'b1;
            msup_pkg::ST_INIT:   cmd.init_div = 1'b1;
            msup_pkg::ST_DIV:    cmd.step_div = 1'b1;
            msup_pkg::ST_RESULT: cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result loaded over a word not yet taken");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == msup_pkg::ST_MUL)
        else $error("accepted word did not start the multiply");
    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msup_pkg::ST_DIV && status.div_last) |=> state_reg == msup_pkg::ST_RESULT)
        else $error("division did not finish into the result state");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not offered");

endmodule

// File: sv/msup_dpath.sv
// Datapath of the motor unit message supervisor: settings, held message data,
// miss counters, multiplier, shift-subtract divider and result register. Uses msup_pkg.
module msup_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  msup_pkg::in_item_t  item,
    input  msup_pkg::cmd_t      cmd,
    output msup_pkg::status_t   status,
    output msup_pkg::out_item_t result
);

    logic [19:0] max_power_reg;
    logic [15:0] uv_limit_reg;
    logic [7:0]  to_limit_reg;

    logic [15:0] volt_reg, volt_next;
    logic [15:0] accel_reg, accel_next;
    logic        ign_reg, ign_next;
    logic [7:0]  miss_reg [msup_pkg::NUM_SRC];
    logic [7:0]  miss_next [msup_pkg::NUM_SRC];
    logic [msup_pkg::NUM_SRC-1:0] flag_reg, flag_next, arrived;
    logic [15:0] torque_reg, speed_reg;

    logic [35:0] num_reg;
    logic [22:0] den_reg;
    logic [22:0] rem_reg, rem_next;
    logic [15:0] low_reg, quo_reg;
    logic [3:0]  cnt_reg;
    logic        sat_reg;
    logic [23:0] trial;
    logic        ge;

    msup_pkg::out_item_t out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_power_reg <= msup_pkg::MAX_POWER_RST;
            uv_limit_reg <= msup_pkg::UV_LIMIT_RST;
            to_limit_reg <= msup_pkg::TO_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                msup_pkg::CFG_MAX_POWER: max_power_reg <= cfg_data;
                msup_pkg::CFG_UV_LIMIT:  uv_limit_reg <= cfg_data[15:0];
                msup_pkg::CFG_TO_LIMIT:  to_limit_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign arrived[msup_pkg::SRC_BATTERY] = item.battery_msg_valid;
    assign arrived[msup_pkg::SRC_GEARBOX] = item.gearbox_msg_valid;
    assign arrived[msup_pkg::SRC_VEHICLE] = item.vehicle_msg_valid;

    always_comb begin
        volt_next = item.battery_msg_valid ? {item.battery_byte0, item.battery_byte1} : volt_reg;
        accel_next = item.vehicle_msg_valid ? {item.vehicle_byte1, item.vehicle_byte0}
                                            : accel_reg;
        ign_next = item.vehicle_msg_valid ? item.vehicle_byte2[0] : ign_reg;
        for (int i = 0; i < msup_pkg::NUM_SRC; i++) begin
            if (arrived[i]) begin
                miss_next[i] = '0;
                flag_next[i] = 1'b0;
            end else begin
                // The counter sticks at full scale, so a limit of 255 never trips.
                miss_next[i] = (miss_reg[i] == 8'hFF) ? miss_reg[i] : miss_reg[i] + 8'd1;
                flag_next[i] = flag_reg[i] | (miss_next[i] > to_limit_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_reg <= '0;
            accel_reg <= '0;
            ign_reg <= 1'b0;
            flag_reg <= '0;
            for (int i = 0; i < msup_pkg::NUM_SRC; i++) begin
                miss_reg[i] <= '0;
            end
        end else if (cmd.accept) begin
            volt_reg <= volt_next;
            accel_reg <= accel_next;
            ign_reg <= ign_next;
            flag_reg <= flag_next;
            for (int i = 0; i < msup_pkg::NUM_SRC; i++) begin
                miss_reg[i] <= miss_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            torque_reg <= item.motor_torque;
            speed_reg <= item.motor_speed;
        end
    end

    // The quotient exceeds 16 bits exactly when the top 20 bits of the
    // product are not below the divisor; that also covers a zero divisor.
    assign trial = {rem_reg, low_reg[15]};
    assign ge = trial >= {1'b0, den_reg};
    assign rem_next = ge ? 23'(trial - {1'b0, den_reg}) : trial[22:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_mul) begin
            num_reg <= {16'd0, max_power_reg} * {20'd0, accel_reg};
            den_reg <= 23'({7'd0, volt_reg} * {16'd0, msup_pkg::PERCENT_SCALE});
        end
        if (cmd.init_div) begin
            sat_reg <= {3'd0, num_reg[35:16]} >= den_reg;
            rem_reg <= {3'd0, num_reg[35:16]};
            low_reg <= num_reg[15:0];
            cnt_reg <= '0;
        end else if (cmd.step_div) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[14:0], 1'b0};
            quo_reg <= {quo_reg[14:0], ge};
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    assign status.div_last = cnt_reg == 4'(msup_pkg::DIV_STEPS - 1);

    always_comb begin
        out_next = '0;
        out_next.torque_word = torque_reg;
        out_next.speed_word = speed_reg;
        out_next.error_code = (|flag_reg) ? msup_pkg::ERR_TIMEOUT : msup_pkg::ERR_NONE;
        if (ign_reg) begin
            if (volt_reg < uv_limit_reg) begin
                out_next.error_code = msup_pkg::ERR_UNDERVOLT;
            end else if (!(|flag_reg)) begin
                out_next.motor_voltage = volt_reg;
                out_next.motor_current = sat_reg ? msup_pkg::CURRENT_MAX : quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

    a_flag_needs_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && item.gearbox_msg_valid |=> !flag_reg[msup_pkg::SRC_GEARBOX])
        else $error("timeout flag survived an arrival");
    a_err_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (result.error_code != 2'd3))
        else $error("undefined error code produced");
    a_off_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && !ign_reg |=> result.motor_voltage == '0 && result.motor_current == '0)
        else $error("drive commanded with ignition off");

endmodule

// File: sv/motor_unit_message_supervisor_unit.sv
// Top level of the motor unit message supervisor.
// Instantiates msup_ctrl and msup_dpath; types come from msup_pkg.
//
//   channel   direction  handshake             payload
//   s_        in         s_tvalid / s_tready   s_tdata, one control tick
//   m_        out        m_tvalid / m_tready   m_tdata, one result word
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Held data and miss counters update on the accepting edge. The result is offered
// after one multiply, one divider set-up, 16 restoring divider steps and a load
// of the output register. A new word is not taken until that result is loaded.
// A result waiting on m_tready holds the block in its last state, but the next
// word is accepted as soon as that result is loaded. Reset is synchronous and
// active low; configuration writes are always taken.
module motor_unit_message_supervisor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // battery_msg_valid, battery_byte0, battery_byte1, gearbox_msg_valid,
    // vehicle_msg_valid, vehicle_byte0, vehicle_byte1, vehicle_byte2,
    // motor_torque, motor_speed, then zero fill
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // error_code, motor_voltage, motor_current, torque_word, speed_word, then zero fill
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    msup_pkg::cmd_t      cmd;
    msup_pkg::status_t   status;
    msup_pkg::in_item_t  item;
    msup_pkg::out_item_t result;

    assign cfg_ready = 1'b1;
    assign item = msup_pkg::in_item_t'(s_tdata[74:0]);
    assign m_tdata = {6'd0, result};

    msup_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msup_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
